@@ rtl/core/sssp_pkg.sv @@
`default_nettype none

package sssp_pkg;

  localparam int VertexWidth   = 5;
  localparam int WeightWidth   = 16;
  localparam int DistWidth     = 32;
  localparam int CfgWidth      = 6;
  localparam int CfgIndexWidth = 1;

  localparam logic [CfgIndexWidth-1:0] CFG_VERTEX_COUNT  = 1'b0;
  localparam logic [CfgIndexWidth-1:0] CFG_SOURCE_VERTEX = 1'b1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  typedef struct packed {
    logic                          kind;
    logic [VertexWidth-1:0]        edge_from;
    logic [VertexWidth-1:0]        edge_to;
    logic signed [WeightWidth-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [VertexWidth-1:0]      vertex;
    logic signed [DistWidth-1:0] distance;
    logic                        reachable;
    logic                        negative_cycle;
    logic                        edges_dropped;
    logic                        last;
  } out_item_t;

  typedef struct packed {
    logic [VertexWidth-1:0]        tail;
    logic [VertexWidth-1:0]        head;
    logic signed [WeightWidth-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic                        ok;
    logic signed [DistWidth-1:0] val;
  } dist_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_EREAD,
    S_DREAD,
    S_RELAX,
    S_OSEL,
    S_OREAD,
    S_OWAIT
  } sssp_state_e;

  typedef struct packed {
    logic load;
    logic run_start;
    logic vtx_clr;
    logic vtx_inc;
    logic init_wr;
    logic edge_rd;
    logic dist_rd;
    logic relax;
    logic out_rd;
    logic out_push;
    logic out_push_cyc;
  } sssp_cmd_t;

  typedef struct packed {
    logic vtx_last;
    logic edge_last;
    logic edge_none;
    logic check_pass;
    logic cycle_found;
    logic out_free;
  } sssp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/sssp_stream_if.sv @@
`default_nettype none

interface sssp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/core/single_source_shortest_paths.sv @@
// Bellman-Ford shortest paths. A load item (kind 0) stores one directed edge;
// edges past MAX_EDGES are dropped and flagged in the results.
// A run item (kind 1) first seeds the distance store for each of the n
// vertices, with n the clamped vertex count; then, if any edges are stored, n
// passes (n-1 relaxing, one negative-cycle check) walk them in load order,
// each edge going through an edge store read, a distance read and a compare and update.
// Results leave one per vertex, or as one negative-cycle item. No input is
// taken until the last result of a run sits in the output register. The edge
// store empties at the end of every run; no clearing pass follows reset.
`default_nettype none

module single_source_shortest_paths #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sssp_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [sssp_pkg::CfgWidth-1:0]      cfg_data_i,
  sssp_stream_if.sink                        in_i,
  sssp_stream_if.source                      out_o
);

  sssp_pkg::sssp_cmd_t    cmd;
  sssp_pkg::sssp_status_t status;
  sssp_pkg::in_item_t     in_item;
  sssp_pkg::edge_t        edge_in;
  sssp_pkg::out_item_t    out_item;
  logic                   in_ready;
  logic                   out_valid;

  assign in_item        = in_i.payload;
  assign edge_in.tail   = in_item.edge_from;
  assign edge_in.head   = in_item.edge_to;
  assign edge_in.weight = in_item.edge_weight;

  sssp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_item.kind),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sssp_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .edge_i      (edge_in),
    .out_item_o  (out_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_item;

endmodule

`default_nettype wire

@@ rtl/core/sssp_ctrl.sv @@
`default_nettype none

module sssp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_kind_i,
  output logic                  in_ready_o,
  input  sssp_pkg::sssp_status_t status_i,
  output sssp_pkg::sssp_cmd_t    cmd_o
);

  sssp_pkg::sssp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sssp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sssp_pkg::S_IDLE: begin
        if (in_valid_i && (in_kind_i == sssp_pkg::KIND_RUN)) state_d = sssp_pkg::S_INIT;
      end
      sssp_pkg::S_INIT: begin
        if (status_i.vtx_last) begin
          state_d = status_i.edge_none ? sssp_pkg::S_OSEL : sssp_pkg::S_EREAD;
        end
      end
      sssp_pkg::S_EREAD: state_d = sssp_pkg::S_DREAD;
      sssp_pkg::S_DREAD: state_d = sssp_pkg::S_RELAX;
      sssp_pkg::S_RELAX: begin
        if (status_i.edge_last && status_i.check_pass) state_d = sssp_pkg::S_OSEL;
        else state_d = sssp_pkg::S_EREAD;
      end
      sssp_pkg::S_OSEL: begin
        if (!status_i.cycle_found) state_d = sssp_pkg::S_OREAD;
        else if (status_i.out_free) state_d = sssp_pkg::S_IDLE;
      end
      sssp_pkg::S_OREAD: state_d = sssp_pkg::S_OWAIT;
      sssp_pkg::S_OWAIT: begin
        if (status_i.out_free) begin
          state_d = status_i.vtx_last ? sssp_pkg::S_IDLE : sssp_pkg::S_OREAD;
        end
      end
      default: state_d = sssp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sssp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == sssp_pkg::KIND_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.run_start = 1'b1;
            cmd_o.vtx_clr   = 1'b1;
          end
        end
      end
      sssp_pkg::S_INIT: begin
        cmd_o.init_wr = 1'b1;
        cmd_o.vtx_inc = 1'b1;
        if (status_i.vtx_last) cmd_o.vtx_clr = 1'b1;
      end
      sssp_pkg::S_EREAD: cmd_o.edge_rd = 1'b1;
      sssp_pkg::S_DREAD: cmd_o.dist_rd = 1'b1;
      sssp_pkg::S_RELAX: cmd_o.relax = 1'b1;
      sssp_pkg::S_OSEL: begin
        if (status_i.cycle_found && status_i.out_free) cmd_o.out_push_cyc = 1'b1;
      end
      sssp_pkg::S_OREAD: cmd_o.out_rd = 1'b1;
      sssp_pkg::S_OWAIT: begin
        if (status_i.out_free) begin
          cmd_o.out_push = 1'b1;
          cmd_o.vtx_inc  = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/sssp_datapath.sv @@
`default_nettype none

module sssp_datapath #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sssp_pkg::sssp_cmd_t                  cmd_i,
  output sssp_pkg::sssp_status_t               status_o,
  input  logic                                 cfg_we_i,
  input  logic [sssp_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [sssp_pkg::CfgWidth-1:0]        cfg_data_i,
  input  sssp_pkg::edge_t                      edge_i,
  output sssp_pkg::out_item_t                  out_item_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);

  logic [sssp_pkg::CfgWidth-1:0]    vcount_q;
  logic [sssp_pkg::VertexWidth-1:0] source_q;
  logic [VCW-1:0]                   n;
  logic                             src_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= sssp_pkg::CfgWidth'(1);
      source_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sssp_pkg::CFG_VERTEX_COUNT:  vcount_q <= cfg_data_i;
        sssp_pkg::CFG_SOURCE_VERTEX: source_q <= cfg_data_i[sssp_pkg::VertexWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vcount_q == '0) n = VCW'(1);
    else if (int'(vcount_q) > MAX_VERTICES) n = VCW'(MAX_VERTICES);
    else n = VCW'(vcount_q);
  end

  assign src_ok = int'(source_q) < int'(n);

  // edge store
  sssp_pkg::edge_t edge_mem [MAX_EDGES];
  sssp_pkg::edge_t edge_q;
  logic [ETW-1:0]  edge_total_q;
  logic [ETW-1:0]  edge_idx_q;
  logic            overflow_q;
  logic            edge_full;
  logic            edge_we;
  logic            run_done;

  assign edge_full = edge_total_q == ETW'(MAX_EDGES);
  assign edge_we   = cmd_i.load && !edge_full;

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_total_q[EAW-1:0]] <= edge_i;
    if (cmd_i.edge_rd) edge_q <= edge_mem[edge_idx_q[EAW-1:0]];
  end

  // distance store
  sssp_pkg::dist_t dist_mem [MAX_VERTICES];
  sssp_pkg::dist_t rd_a_q, rd_b_q;
  sssp_pkg::dist_t dist_wdata;
  logic [VW-1:0]   vtx_q;
  logic [VW-1:0]   addr_a, addr_b, dist_waddr;
  logic            dist_we;

  logic [VCW-1:0]  pass_q;
  logic            check_q;
  logic            cycle_q;
  logic            vtx_last;
  logic            edge_last;

  logic                    u_ok, v_ok, init_ok, less, changed;
  logic signed [32:0]      cand, dv_ext;
  logic signed [31:0]      cand_sat;

  assign u_ok    = int'(edge_q.tail) < int'(n);
  assign v_ok    = int'(edge_q.head) < int'(n);
  assign init_ok = src_ok && (int'(vtx_q) == int'(source_q));

  assign cand    = {rd_a_q.val[31], rd_a_q.val} + {{17{edge_q.weight[15]}}, edge_q.weight};
  assign dv_ext  = {rd_b_q.val[31], rd_b_q.val};
  assign less    = cand < dv_ext;
  assign changed = u_ok && v_ok && rd_a_q.ok && (!rd_b_q.ok || less);

  always_comb begin
    if (cand[32] != cand[31]) cand_sat = cand[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else cand_sat = cand[31:0];
  end

  assign addr_a     = cmd_i.out_rd ? vtx_q : VW'(edge_q.tail);
  assign addr_b     = VW'(edge_q.head);
  assign dist_we    = cmd_i.init_wr || (cmd_i.relax && changed && !check_q);
  assign dist_waddr = cmd_i.init_wr ? vtx_q : VW'(edge_q.head);

  always_comb begin
    if (cmd_i.init_wr) begin
      dist_wdata.ok  = init_ok;
      dist_wdata.val = '0;
    end else begin
      dist_wdata.ok  = 1'b1;
      dist_wdata.val = cand_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    if (cmd_i.dist_rd || cmd_i.out_rd) rd_a_q <= dist_mem[addr_a];
    if (cmd_i.dist_rd) rd_b_q <= dist_mem[addr_b];
  end

  assign vtx_last  = (int'(vtx_q) + 1) == int'(n);
  assign edge_last = (edge_idx_q + ETW'(1)) == edge_total_q;
  assign run_done  = (cmd_i.out_push && vtx_last) || cmd_i.out_push_cyc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_total_q <= '0;
      overflow_q   <= 1'b0;
    end else if (run_done) begin
      edge_total_q <= '0;
      overflow_q   <= 1'b0;
    end else if (cmd_i.load) begin
      if (edge_full) overflow_q <= 1'b1;
      else edge_total_q <= edge_total_q + ETW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_q      <= '0;
      edge_idx_q <= '0;
      pass_q     <= '0;
      check_q    <= 1'b0;
      cycle_q    <= 1'b0;
    end else begin
      if (cmd_i.vtx_clr) vtx_q <= '0;
      else if (cmd_i.vtx_inc) vtx_q <= vtx_q + VW'(1);

      if (cmd_i.run_start) begin
        edge_idx_q <= '0;
        pass_q     <= '0;
        check_q    <= n == VCW'(1);
        cycle_q    <= 1'b0;
      end else if (cmd_i.relax) begin
        edge_idx_q <= edge_last ? '0 : edge_idx_q + ETW'(1);
        if (check_q && changed) cycle_q <= 1'b1;
        if (edge_last && !check_q) begin
          pass_q  <= pass_q + VCW'(1);
          check_q <= (int'(pass_q) + 2) >= int'(n);
        end
      end
    end
  end

  // result register
  logic                out_valid_q;
  sssp_pkg::out_item_t out_q;
  logic                out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_push || cmd_i.out_push_cyc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_push) begin
      out_q.vertex         <= sssp_pkg::VertexWidth'(vtx_q);
      out_q.distance       <= rd_a_q.ok ? rd_a_q.val : '0;
      out_q.reachable      <= rd_a_q.ok;
      out_q.negative_cycle <= 1'b0;
      out_q.edges_dropped  <= overflow_q;
      out_q.last           <= vtx_last;
    end else if (cmd_i.out_push_cyc) begin
      out_q.vertex         <= '0;
      out_q.distance       <= '0;
      out_q.reachable      <= 1'b0;
      out_q.negative_cycle <= 1'b1;
      out_q.edges_dropped  <= overflow_q;
      out_q.last           <= 1'b1;
    end
  end

  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

  assign status_o.vtx_last    = vtx_last;
  assign status_o.edge_last   = edge_last;
  assign status_o.edge_none   = edge_total_q == '0;
  assign status_o.check_pass  = check_q;
  assign status_o.cycle_found = cycle_q;
  assign status_o.out_free    = out_free;

  a_full_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && edge_full && !run_done |=> overflow_q && (edge_total_q == $past(edge_total_q)))
    else $error("edge offered to a full store was not dropped");

  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_done |=> (edge_total_q == '0) && !overflow_q)
    else $error("edge store not emptied after run");

  a_relax_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.relax && dist_we |-> v_ok && u_ok && !check_q)
    else $error("distance written for an edge outside the graph");

  a_push_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_push || cmd_i.out_push_cyc) |-> out_free)
    else $error("result loaded over one not yet transferred");

endmodule

`default_nettype wire

@@ sim/single_source_shortest_paths_tb.sv @@
`timescale 1ns / 100ps

module single_source_shortest_paths_tb;

  localparam int MAX_V      = 32;
  localparam int EDGE_SLOTS = 256;
  localparam int SETTLE     = 8;
  localparam int TAIL       = 40;
  localparam int LIMIT      = 1000000;
  localparam longint DIST_HI = 64'sd2147483647;
  localparam longint DIST_LO = -64'sd2147483648;

  class path_scoreboard;
    sssp_pkg::edge_t                       edges[$];
    bit                                    dropped;
    logic [sssp_pkg::CfgWidth-1:0]         vcount = 1;
    logic [sssp_pkg::VertexWidth-1:0]      source = 0;
    logic signed [sssp_pkg::DistWidth-1:0] best_dist[MAX_V];
    bit                                    reached[MAX_V];
    sssp_pkg::out_item_t                   due_results[$];
    int                                    errors, transfers, runs, cycle_runs, checked;

    function bit relax_edges(int unsigned n, bit apply);
      bit          changed;
      longint      cand;
      int unsigned u, v;
      changed = 1'b0;
      foreach (edges[e]) begin
        u = edges[e].tail;
        v = edges[e].head;
        if (u >= n || v >= n || !reached[u]) continue;
        cand = longint'(best_dist[u]) + longint'($signed(edges[e].weight));
        if (!reached[v] || cand < longint'(best_dist[v])) begin
          changed = 1'b1;
          if (apply) begin
            if (cand > DIST_HI) cand = DIST_HI;
            if (cand < DIST_LO) cand = DIST_LO;
            best_dist[v] = cand[sssp_pkg::DistWidth-1:0];
            reached[v]   = 1'b1;
          end
        end
      end
      return changed;
    endfunction

    function void note_transfer(sssp_pkg::in_item_t it);
      int unsigned         n;
      sssp_pkg::edge_t     ed;
      sssp_pkg::out_item_t want;
      transfers++;
      if (it.kind == sssp_pkg::KIND_LOAD) begin
        if (edges.size() < EDGE_SLOTS) begin
          ed.tail   = it.edge_from;
          ed.head   = it.edge_to;
          ed.weight = it.edge_weight;
          edges.push_back(ed);
        end else begin
          dropped = 1'b1;
        end
        return;
      end
      runs++;
      n = (vcount == 0) ? 1 : ((vcount > MAX_V) ? MAX_V : vcount);
      foreach (best_dist[i]) begin
        best_dist[i] = '0;
        reached[i]   = 1'b0;
      end
      if (source < n) reached[source] = 1'b1;
      for (int unsigned p = 0; p + 1 < n; p++) void'(relax_edges(n, 1'b1));
      want = '0;
      want.edges_dropped = dropped;
      if (relax_edges(n, 1'b0)) begin
        cycle_runs++;
        want.negative_cycle = 1'b1;
        want.last           = 1'b1;
        due_results.push_back(want);
      end else begin
        for (int unsigned i = 0; i < n; i++) begin
          want.vertex    = sssp_pkg::VertexWidth'(i);
          want.reachable = reached[i];
          want.distance  = reached[i] ? best_dist[i] : '0;
          want.last      = (i + 1 == n);
          due_results.push_back(want);
        end
      end
      edges.delete();
      dropped = 1'b0;
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(sssp_pkg::out_item_t got);
      sssp_pkg::out_item_t want;
      if (due_results.size() == 0) begin
        $error("result for vertex %0d with nothing outstanding", got.vertex);
        errors++;
        return;
      end
      want = due_results.pop_front();
      checked++;
      compare_field("vertex", want.vertex, got.vertex);
      compare_field("distance", want.distance, got.distance);
      compare_field("reachable", want.reachable, got.reachable);
      compare_field("negative_cycle", want.negative_cycle, got.negative_cycle);
      compare_field("edges_dropped", want.edges_dropped, got.edges_dropped);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [sssp_pkg::CfgIndexWidth-1:0] cfg_index_i;
  logic [sssp_pkg::CfgWidth-1:0]      cfg_data_i;
  bit                                 quiet;
  longint                             cycles;
  path_scoreboard                     paths = new;

  sssp_stream_if #(.payload_t(sssp_pkg::in_item_t))  in_if ();
  sssp_stream_if #(.payload_t(sssp_pkg::out_item_t)) out_if ();

  single_source_shortest_paths #(
    .MAX_VERTICES(MAX_V),
    .MAX_EDGES   (EDGE_SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) paths.note_transfer(in_if.payload);
    if (rst_ni && out_if.valid && out_if.ready) paths.check_result(out_if.payload);
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver: ready held until a transfer, then an occasional stall
  initial begin
    int gap;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  task automatic push_item(sssp_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic wait_drain(int settle);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (paths.due_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic configure(logic [sssp_pkg::CfgWidth-1:0] vc,
                           logic [sssp_pkg::VertexWidth-1:0] src);
    wait_drain(SETTLE);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sssp_pkg::CFG_VERTEX_COUNT;
    cfg_data_i  <= vc;
    @(posedge clk_i);
    cfg_index_i <= sssp_pkg::CFG_SOURCE_VERTEX;
    cfg_data_i  <= sssp_pkg::CfgWidth'(src);
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    paths.vcount = vc;
    paths.source = src;
  endtask

  function automatic sssp_pkg::in_item_t random_edge(int unsigned span);
    sssp_pkg::in_item_t it;
    int unsigned        r;
    it.kind = sssp_pkg::KIND_LOAD;
    if ($urandom_range(0, 99) < 85) begin
      it.edge_from = sssp_pkg::VertexWidth'($urandom_range(0, span - 1));
      it.edge_to   = sssp_pkg::VertexWidth'($urandom_range(0, span - 1));
    end else begin
      it.edge_from = sssp_pkg::VertexWidth'($urandom());
      it.edge_to   = sssp_pkg::VertexWidth'($urandom());
    end
    r = $urandom_range(0, 99);
    if (r < 55) it.edge_weight = sssp_pkg::WeightWidth'($urandom_range(0, 100));
    else if (r < 75) it.edge_weight = sssp_pkg::WeightWidth'(-int'($urandom_range(1, 30)));
    else it.edge_weight = sssp_pkg::WeightWidth'($urandom());
    return it;
  endfunction

  task automatic load_edge(int tail, int head, int weight);
    sssp_pkg::in_item_t it;
    it.kind        = sssp_pkg::KIND_LOAD;
    it.edge_from   = sssp_pkg::VertexWidth'(tail);
    it.edge_to     = sssp_pkg::VertexWidth'(head);
    it.edge_weight = sssp_pkg::WeightWidth'(weight);
    push_item(it);
  endtask

  // edge fields of a run transfer are don't-care, so keep them random
  task automatic run_graph();
    sssp_pkg::in_item_t it;
    it      = random_edge(MAX_V);
    it.kind = sssp_pkg::KIND_RUN;
    push_item(it);
  endtask

  initial begin
    int          n_eff, n_edges, rnd_items, graph, r;
    logic [5:0]  vc;
    logic [4:0]  src;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    cycles        = 0;
    quiet         = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // negative edge, weight extremes, out-of-range endpoints
    configure(6'd4, 5'd0);
    load_edge(0, 1, 5);
    load_edge(1, 2, -3);
    load_edge(0, 2, 32767);
    load_edge(2, 3, -32768);
    load_edge(3, 31, 1);
    load_edge(31, 0, -1);
    run_graph();
    // negative cycle not reachable from source, then a reachable one
    configure(6'd3, 5'd1);
    load_edge(0, 2, -7);
    load_edge(2, 0, 2);
    run_graph();
    load_edge(1, 1, -1);
    run_graph();
    // vertex count of zero, then above the maximum
    configure(6'd0, 5'd0);
    load_edge(0, 0, 0);
    run_graph();
    configure(6'd63, 5'd31);
    load_edge(31, 0, -32768);
    load_edge(0, 30, 32767);
    run_graph();
    // source beyond vertex count; empty edge store
    configure(6'd5, 5'd7);
    load_edge(7, 1, 1);
    run_graph();
    configure(6'd32, 5'd0);
    run_graph();

    rnd_items = 0;
    graph     = 0;
    while (rnd_items < 250) begin
      quiet = ($urandom_range(0, 4) == 0);
      if (graph == 4) begin
        // overfill the edge store on a tiny graph
        configure(6'd2, 5'($urandom_range(0, 1)));
        n_edges = EDGE_SLOTS + $urandom_range(1, 6);
        repeat (n_edges) push_item(random_edge(2));
        run_graph();
        rnd_items += n_edges + 1;
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          r = $urandom_range(0, 99);
          if (r < 70) vc = 6'($urandom_range(1, 8));
          else if (r < 90) vc = 6'($urandom_range(9, 32));
          else if (r < 95) vc = 6'd0;
          else vc = 6'($urandom_range(33, 63));
          n_eff = (vc == 0) ? 1 : ((vc > MAX_V) ? MAX_V : vc);
          if ($urandom_range(0, 99) < 85) src = 5'($urandom_range(0, n_eff - 1));
          else src = 5'($urandom_range(0, 31));
          configure(vc, src);
        end
        n_eff   = (paths.vcount == 0) ? 1 :
                  ((paths.vcount > MAX_V) ? MAX_V : paths.vcount);
        n_edges = (n_eff > 12) ? $urandom_range(0, 40) : $urandom_range(0, 14);
        if ($urandom_range(0, 9) == 0) n_edges = 0;
        repeat (n_edges) push_item(random_edge(n_eff));
        run_graph();
        rnd_items += n_edges + 1;
      end
      graph++;
    end

    quiet = 1'b0;
    wait_drain(TAIL);
    if (paths.due_results.size() != 0) begin
      $error("%0d results never arrived", paths.due_results.size());
      paths.errors++;
    end
    $display("Covered %0d input transfers and %0d runs, %0d of them ending in a negative cycle,",
             paths.transfers, paths.runs, paths.cycle_runs);
    $display("including an overfilled edge store; %0d results compared field by field.",
             paths.checked);
    if (paths.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sssp_pkg.sv
rtl/core/sssp_stream_if.sv
rtl/core/sssp_ctrl.sv
rtl/core/sssp_datapath.sv
rtl/core/single_source_shortest_paths.sv
sim/single_source_shortest_paths_tb.sv
